>>> rtl/fvg_pkg.sv
// Shared types and constants of the fair value gap tracker.
`timescale 1ns / 1ps

package fvg_pkg;

   localparam int MAX_GAPS  = 32;
   localparam int SLOT_BITS = (MAX_GAPS > 1) ? $clog2(MAX_GAPS) : 1;
   localparam int PRICE_W   = 32;
   localparam int INDEX_W   = 32;

   localparam logic [SLOT_BITS-1:0] LAST_SLOT = SLOT_BITS'(MAX_GAPS - 1);

   localparam logic [1:0] HIST_NEED = 2'd2;
   localparam logic [INDEX_W-1:0] THIRD_OFFSET = INDEX_W'(2);

   typedef enum logic [1:0] {
      EV_NEW_GAP  = 2'd0,
      EV_FILLED   = 2'd1,
      EV_DROPPED  = 2'd2
   } event_kind_type;

   typedef enum logic [2:0] {
      CSR_UP_ENABLE        = 3'd0,
      CSR_DOWN_ENABLE      = 3'd1,
      CSR_UP_MIN_GAP       = 3'd2,
      CSR_DOWN_MIN_GAP     = 3'd3,
      CSR_UP_HIDE_FILLED   = 3'd4,
      CSR_DOWN_HIDE_FILLED = 3'd5,
      CSR_UP_EXTEND        = 3'd6,
      CSR_DOWN_EXTEND      = 3'd7
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DETECT,
      ST_INSERT,
      ST_FLUSH
   } state_type;

   typedef struct packed {
      logic               is_up;
      logic [INDEX_W-1:0] begin_index;
      logic [PRICE_W-1:0] start_value;
      logic [PRICE_W-1:0] end_value;
   } entry_type;

   typedef struct packed {
      event_kind_type     event_kind;
      logic               is_up;
      logic [INDEX_W-1:0] begin_index;
      logic [PRICE_W-1:0] start_value;
      logic [PRICE_W-1:0] end_value;
      logic [INDEX_W-1:0] end_index;
      logic               hide;
   } result_type;

endpackage

>>> rtl/fair_value_gap_tracker.sv
// Top level of the fair value gap tracker: gap table memory and scan sequencer.
`timescale 1ns / 1ps

// Usage:
//  req_* takes one closed bar per word (high and low in ticks). rsp_* returns
//  the events of that bar: fills in slot order, then at most one new gap or
//  drop; rsp_tlast marks the final word of the bar. A bar with no event
//  returns nothing. csr_* writes a setting; write only while idle.
//  Timing: a bar is taken in idle, then the scan reads the table slots in
//  order from the gap memory (one read port, registered read), then come the
//  detect, insert and flush states; the next bar is taken in idle after the
//  flush. The slot scan over the memory takes most of the time per bar. The
//  first result word appears once the next event of the bar or its end is
//  known, since tlast must be decided first.
//  Reset: settings return to 1, history, bar count and all valid bits clear.
//  The table memory itself is not cleared; valid bits guard every entry.
//  Stall: a result waits in the output register, and one more in a holding
//  register; the scan pauses on a fill and the insert on a new gap while both
//  are occupied, and the flush waits for the output register.
module fair_value_gap_tracker (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [63:0]  req_tdata,   // bar_high[31:0], bar_low[63:32]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [135:0] rsp_tdata,   // begin_index, start_value, end_value, end_index, hide
   output logic [2:0]   rsp_tuser,   // event_kind[1:0], is_up[2]
   output logic         rsp_tlast,
   input  logic         csr_wr_en,
   input  logic [2:0]   csr_index,
   input  logic [31:0]  csr_wdata
);

   // settings
   logic                        up_enable_ff, down_enable_ff;
   logic [31:0]                 up_min_gap_ff, down_min_gap_ff;
   logic                        up_hide_ff, down_hide_ff;
   logic                        up_extend_ff, down_extend_ff;

   fvg_pkg::state_type          state_ff, state_in;
   logic [fvg_pkg::PRICE_W-1:0] bar_high_ff, bar_high_in, bar_low_ff, bar_low_in;
   logic [fvg_pkg::PRICE_W-1:0] prior_high_ff [2];
   logic [fvg_pkg::PRICE_W-1:0] prior_low_ff [2];
   logic                        hist_adv;
   logic [1:0]                  hist_ff;
   logic [fvg_pkg::INDEX_W-1:0] bar_count_ff;
   logic [fvg_pkg::MAX_GAPS-1:0] gap_valid_ff, gap_valid_in;

   logic [fvg_pkg::SLOT_BITS-1:0] idx_ff, idx_in;
   logic                        free_found_ff, free_found_in;
   logic [fvg_pkg::SLOT_BITS-1:0] free_idx_ff, free_idx_in;

   logic                        det_valid_ff, det_valid_in;
   logic                        det_up_ff, det_up_in;
   logic [fvg_pkg::PRICE_W-1:0] det_start_ff, det_start_in, det_end_ff, det_end_in;

   // gap table memory
   fvg_pkg::entry_type          gap_mem [fvg_pkg::MAX_GAPS];
   fvg_pkg::entry_type          rd_data_ff;
   logic [fvg_pkg::SLOT_BITS-1:0] rd_addr;
   logic                        mem_we;
   logic [fvg_pkg::SLOT_BITS-1:0] mem_wa;
   fvg_pkg::entry_type          mem_wd;

   // output register and holding register
   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        rsp_last_ff, rsp_last_in;
   fvg_pkg::result_type         rsp_ff, rsp_in;
   logic                        pend_valid_ff, pend_valid_in;
   fvg_pkg::result_type         pend_ff, pend_in;

   logic                        rsp_free, can_put;
   logic                        slot_valid, slot_hit;
   logic                        up_hit, dn_hit;
   fvg_pkg::result_type         fill_res, new_res;

   assign req_tready = (state_ff == fvg_pkg::ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = {rsp_ff.is_up, rsp_ff.event_kind};
   assign rsp_tdata  = {7'd0, rsp_ff.hide, rsp_ff.end_index, rsp_ff.end_value,
                        rsp_ff.start_value, rsp_ff.begin_index};

   assign rsp_free = !rsp_valid_ff || rsp_tready;
   assign can_put  = !pend_valid_ff || rsp_free;

   // fill test on the slot under scan
   assign slot_valid = gap_valid_ff[idx_ff];
   assign slot_hit   = slot_valid && (rd_data_ff.is_up ? (bar_low_ff <= rd_data_ff.start_value)
                                                       : (bar_high_ff >= rd_data_ff.start_value));

   always_comb begin
      fill_res.event_kind  = fvg_pkg::EV_FILLED;
      fill_res.is_up       = rd_data_ff.is_up;
      fill_res.begin_index = rd_data_ff.begin_index;
      fill_res.start_value = rd_data_ff.start_value;
      fill_res.end_value   = rd_data_ff.end_value;
      fill_res.end_index   = (rd_data_ff.is_up ? up_extend_ff : down_extend_ff)
                             ? bar_count_ff : rd_data_ff.begin_index + fvg_pkg::THIRD_OFFSET;
      fill_res.hide        = rd_data_ff.is_up ? up_hide_ff : down_hide_ff;

      new_res.event_kind   = free_found_ff ? fvg_pkg::EV_NEW_GAP : fvg_pkg::EV_DROPPED;
      new_res.is_up        = det_up_ff;
      new_res.begin_index  = bar_count_ff - fvg_pkg::THIRD_OFFSET;
      new_res.start_value  = det_start_ff;
      new_res.end_value    = det_end_ff;
      new_res.end_index    = bar_count_ff;
      new_res.hide         = 1'b0;
   end

   // gap detection against the bar two back
   assign up_hit = (hist_ff == fvg_pkg::HIST_NEED) && up_enable_ff
                   && (prior_high_ff[1] < bar_low_ff)
                   && ((bar_low_ff - prior_high_ff[1]) >= up_min_gap_ff);
   assign dn_hit = (hist_ff == fvg_pkg::HIST_NEED) && down_enable_ff
                   && (prior_low_ff[1] > bar_high_ff)
                   && ((prior_low_ff[1] - bar_high_ff) >= down_min_gap_ff);

   always_comb begin
      state_in      = state_ff;
      bar_high_in   = bar_high_ff;
      bar_low_in    = bar_low_ff;
      gap_valid_in  = gap_valid_ff;
      idx_in        = idx_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      det_valid_in  = det_valid_ff;
      det_up_in     = det_up_ff;
      det_start_in  = det_start_ff;
      det_end_in    = det_end_ff;
      rd_addr       = '0;
      mem_we        = 1'b0;
      mem_wa        = free_idx_ff;
      mem_wd.is_up       = det_up_ff;
      mem_wd.begin_index = new_res.begin_index;
      mem_wd.start_value = det_start_ff;
      mem_wd.end_value   = det_end_ff;
      hist_adv      = 1'b0;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_last_in   = rsp_last_ff;
      rsp_in        = rsp_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;

      unique case (state_ff)
         fvg_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               bar_high_in   = req_tdata[31:0];
               bar_low_in    = req_tdata[63:32];
               idx_in        = '0;
               free_found_in = 1'b0;
               state_in      = fvg_pkg::ST_SCAN;
            end
         end
         fvg_pkg::ST_SCAN: begin
            rd_addr = idx_ff;
            if (!slot_hit || can_put) begin
               if (slot_hit) begin
                  if (pend_valid_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_in       = pend_ff;
                     rsp_last_in  = 1'b0;
                  end
                  pend_valid_in        = 1'b1;
                  pend_in              = fill_res;
                  gap_valid_in[idx_ff] = 1'b0;
               end
               if (!free_found_ff && (!slot_valid || slot_hit)) begin
                  free_found_in = 1'b1;
                  free_idx_in   = idx_ff;
               end
               if (idx_ff == fvg_pkg::LAST_SLOT) begin
                  rd_addr  = '0;
                  state_in = fvg_pkg::ST_DETECT;
               end else begin
                  idx_in  = idx_ff + 1'b1;
                  rd_addr = idx_ff + 1'b1;
               end
            end
         end
         fvg_pkg::ST_DETECT: begin
            det_valid_in = up_hit || dn_hit;
            det_up_in    = up_hit;
            det_start_in = up_hit ? prior_high_ff[1] : prior_low_ff[1];
            det_end_in   = up_hit ? bar_low_ff : bar_high_ff;
            state_in     = fvg_pkg::ST_INSERT;
         end
         fvg_pkg::ST_INSERT: begin
            if (!det_valid_ff) begin
               hist_adv = 1'b1;
               state_in = fvg_pkg::ST_FLUSH;
            end else if (can_put) begin
               if (pend_valid_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_in       = pend_ff;
                  rsp_last_in  = 1'b0;
               end
               pend_valid_in = 1'b1;
               pend_in       = new_res;
               if (free_found_ff) begin
                  mem_we                    = 1'b1;
                  gap_valid_in[free_idx_ff] = 1'b1;
               end
               hist_adv = 1'b1;
               state_in = fvg_pkg::ST_FLUSH;
            end
         end
         fvg_pkg::ST_FLUSH: begin
            if (!pend_valid_ff) begin
               state_in = fvg_pkg::ST_IDLE;
            end else if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_in        = pend_ff;
               rsp_last_in   = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = fvg_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = fvg_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         gap_mem[mem_wa] <= mem_wd;
      end
      rd_data_ff <= gap_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         up_enable_ff    <= 1'b1;
         down_enable_ff  <= 1'b1;
         up_min_gap_ff   <= 32'd1;
         down_min_gap_ff <= 32'd1;
         up_hide_ff      <= 1'b1;
         down_hide_ff    <= 1'b1;
         up_extend_ff    <= 1'b1;
         down_extend_ff  <= 1'b1;
      end else if (csr_wr_en) begin
         unique case (fvg_pkg::csr_index_type'(csr_index))
            fvg_pkg::CSR_UP_ENABLE:        up_enable_ff    <= csr_wdata[0];
            fvg_pkg::CSR_DOWN_ENABLE:      down_enable_ff  <= csr_wdata[0];
            fvg_pkg::CSR_UP_MIN_GAP:       up_min_gap_ff   <= csr_wdata;
            fvg_pkg::CSR_DOWN_MIN_GAP:     down_min_gap_ff <= csr_wdata;
            fvg_pkg::CSR_UP_HIDE_FILLED:   up_hide_ff      <= csr_wdata[0];
            fvg_pkg::CSR_DOWN_HIDE_FILLED: down_hide_ff    <= csr_wdata[0];
            fvg_pkg::CSR_UP_EXTEND:        up_extend_ff    <= csr_wdata[0];
            fvg_pkg::CSR_DOWN_EXTEND:      down_extend_ff  <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= fvg_pkg::ST_IDLE;
         gap_valid_ff     <= '0;
         hist_ff          <= 2'd0;
         bar_count_ff     <= '0;
         prior_high_ff[0] <= '0;
         prior_high_ff[1] <= '0;
         prior_low_ff[0]  <= '0;
         prior_low_ff[1]  <= '0;
         rsp_valid_ff     <= 1'b0;
         pend_valid_ff    <= 1'b0;
         free_found_ff    <= 1'b0;
         det_valid_ff     <= 1'b0;
      end else begin
         state_ff      <= state_in;
         gap_valid_ff  <= gap_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         pend_valid_ff <= pend_valid_in;
         free_found_ff <= free_found_in;
         det_valid_ff  <= det_valid_in;
         if (hist_adv) begin
            prior_high_ff[1] <= prior_high_ff[0];
            prior_low_ff[1]  <= prior_low_ff[0];
            prior_high_ff[0] <= bar_high_ff;
            prior_low_ff[0]  <= bar_low_ff;
            bar_count_ff     <= bar_count_ff + 1'b1;
            if (hist_ff != fvg_pkg::HIST_NEED) begin
               hist_ff <= hist_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      bar_high_ff  <= bar_high_in;
      bar_low_ff   <= bar_low_in;
      idx_ff       <= idx_in;
      free_idx_ff  <= free_idx_in;
      det_up_ff    <= det_up_in;
      det_start_ff <= det_start_in;
      det_end_ff   <= det_end_in;
      rsp_ff       <= rsp_in;
      rsp_last_ff  <= rsp_last_in;
      pend_ff      <= pend_in;
   end

   a_idle_no_pending: assert property (@(posedge clock) disable iff (reset)
      (state_ff == fvg_pkg::ST_IDLE) |-> !pend_valid_ff)
      else $error("result held while idle");

   a_insert_free_slot: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> !gap_valid_ff[mem_wa])
      else $error("new gap written over an open slot");

   a_rsp_from_pending: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(pend_valid_ff))
      else $error("result word shown without a held result");

endmodule

>>> tb/tb_fair_value_gap_tracker.sv
// Self-checking testbench of the fair value gap tracker with a bar-level event predictor.
`timescale 1ns / 1ps

module tb_fair_value_gap_tracker;

   localparam int unsigned CYCLE_LIMIT = 1000000;
   localparam int unsigned SETTLE      = 60;
   localparam int unsigned REPORT_MAX  = 10;

   typedef struct packed {
      fvg_pkg::event_kind_type kind;
      logic           is_up;
      logic [31:0]    begin_idx;
      logic [31:0]    start_val;
      logic [31:0]    end_val;
      logic [31:0]    end_idx;
      logic           hide;
      logic           last;
   } gap_event_type;

   class gap_event_checker;
      bit          up_en, dn_en, up_hide, dn_hide, up_ext, dn_ext;
      bit [31:0]   up_min, dn_min;
      bit [31:0]   high_back[2], low_back[2];
      bit [31:0]   bar_idx;
      int unsigned warm;
      bit          slot_used[fvg_pkg::MAX_GAPS];
      bit          slot_up[fvg_pkg::MAX_GAPS];
      bit [31:0]   slot_begin[fvg_pkg::MAX_GAPS], slot_start[fvg_pkg::MAX_GAPS];
      bit [31:0]   slot_end[fvg_pkg::MAX_GAPS];
      gap_event_type expected_events[$];
      int unsigned errors;

      function new();
         up_en = 1; dn_en = 1; up_min = 1; dn_min = 1;
         up_hide = 1; dn_hide = 1; up_ext = 1; dn_ext = 1;
         high_back = '{0, 0};
         low_back = '{0, 0};
         bar_idx = 0;
         warm = 0;
         foreach (slot_used[s]) slot_used[s] = 0;
         errors = 0;
      endfunction

      function void set_reg(fvg_pkg::csr_index_type idx, logic [31:0] v);
         case (idx)
            fvg_pkg::CSR_UP_ENABLE:        up_en = v[0];
            fvg_pkg::CSR_DOWN_ENABLE:      dn_en = v[0];
            fvg_pkg::CSR_UP_MIN_GAP:       up_min = v;
            fvg_pkg::CSR_DOWN_MIN_GAP:     dn_min = v;
            fvg_pkg::CSR_UP_HIDE_FILLED:   up_hide = v[0];
            fvg_pkg::CSR_DOWN_HIDE_FILLED: dn_hide = v[0];
            fvg_pkg::CSR_UP_EXTEND:        up_ext = v[0];
            fvg_pkg::CSR_DOWN_EXTEND:      dn_ext = v[0];
            default: ;
         endcase
      endfunction

      function int unsigned pending();
         return expected_events.size();
      endfunction

      // store a new gap in the lowest free slot, or report it dropped
      function gap_event_type open_gap(bit up, bit [31:0] sv, bit [31:0] ev_val);
         gap_event_type ev;
         ev.kind = fvg_pkg::EV_DROPPED;
         ev.is_up = up;
         ev.begin_idx = bar_idx - 32'd2;
         ev.start_val = sv;
         ev.end_val = ev_val;
         ev.end_idx = bar_idx;
         ev.hide = 1'b0;
         ev.last = 1'b0;
         for (int s = 0; s < fvg_pkg::MAX_GAPS; s++) begin
            if (!slot_used[s]) begin
               slot_used[s] = 1;
               slot_up[s] = up;
               slot_begin[s] = ev.begin_idx;
               slot_start[s] = sv;
               slot_end[s] = ev_val;
               ev.kind = fvg_pkg::EV_NEW_GAP;
               break;
            end
         end
         return ev;
      endfunction

      function void take_bar(logic [31:0] hi, logic [31:0] lo);
         gap_event_type ev;
         gap_event_type batch[$];
         bit [31:0]  h3, l3;
         bit         ext, up_gap, dn_gap;
         for (int s = 0; s < fvg_pkg::MAX_GAPS; s++) begin
            if (slot_used[s] && (slot_up[s] ? lo <= slot_start[s] : hi >= slot_start[s])) begin
               ext = slot_up[s] ? up_ext : dn_ext;
               ev.kind = fvg_pkg::EV_FILLED;
               ev.is_up = slot_up[s];
               ev.begin_idx = slot_begin[s];
               ev.start_val = slot_start[s];
               ev.end_val = slot_end[s];
               ev.end_idx = ext ? bar_idx : slot_begin[s] + 32'd2;
               ev.hide = slot_up[s] ? up_hide : dn_hide;
               ev.last = 1'b0;
               batch = {batch, ev};
               slot_used[s] = 0;
            end
         end
         if (warm >= 2) begin
            h3 = high_back[1];
            l3 = low_back[1];
            up_gap = up_en && h3 < lo && lo - h3 >= up_min;
            dn_gap = dn_en && l3 > hi && l3 - hi >= dn_min;
            if (up_gap) begin
               batch = {batch, open_gap(1'b1, h3, lo)};
            end else if (dn_gap) begin
               batch = {batch, open_gap(1'b0, l3, hi)};
            end
         end
         high_back[1] = high_back[0];
         low_back[1] = low_back[0];
         high_back[0] = hi;
         low_back[0] = lo;
         if (warm < 2) warm++;
         bar_idx++;
         if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
         expected_events = {expected_events, batch};
      endfunction

      function string show(gap_event_type e);
         return $sformatf({"kind=%0d up=%0b begin=%0d start=%h end=%h",
                           " end_idx=%0d hide=%0b last=%0b"},
                          e.kind, e.is_up, e.begin_idx, e.start_val, e.end_val, e.end_idx,
                          e.hide, e.last);
      endfunction

      function void note_error(string msg);
         errors++;
         if (errors <= REPORT_MAX) $display("%s", msg);
      endfunction

      function void check_event(gap_event_type got);
         gap_event_type exp;
         bit         bad;
         if (expected_events.size() == 0) begin
            note_error($sformatf("unexpected word: %s", show(got)));
            return;
         end
         exp = expected_events.pop_front();
         bad = (got.kind !== exp.kind) || (got.is_up !== exp.is_up)
            || (got.begin_idx !== exp.begin_idx) || (got.start_val !== exp.start_val)
            || (got.end_val !== exp.end_val) || (got.end_idx !== exp.end_idx)
            || (got.hide !== exp.hide) || (got.last !== exp.last);
         if (bad) begin
            note_error($sformatf("mismatch: expected %s, got %s", show(exp), show(got)));
         end
      endfunction
   endclass

   logic          clock = 1'b0;
   logic          reset;
   logic          req_tvalid;
   logic          req_tready;
   logic [63:0]   req_tdata;
   logic          rsp_tvalid;
   logic          rsp_tready = 1'b0;
   logic [135:0]  rsp_tdata;
   logic [2:0]    rsp_tuser;
   logic          rsp_tlast;
   logic          csr_wr_en;
   logic [2:0]    csr_index;
   logic [31:0]   csr_wdata;

   gap_event_checker sb;
   int unsigned      cycles = 0;
   int unsigned      rsp_hold = 0;
   int unsigned      stall;
   bit               no_idle = 0;
   logic [31:0]      market_level = 32'd1000000;

   fair_value_gap_tracker i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("[fair_value_gap_tracker] ERROR");
         $finish;
      end
   end

   function automatic int unsigned idle_len();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 95) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   always @(negedge clock) begin
      if (rsp_hold != 0) begin
         rsp_hold <= rsp_hold - 1;
      end else if (rsp_tready) begin
         stall = idle_len();
         if (stall != 0) begin
            rsp_tready <= 1'b0;
            rsp_hold <= stall - 1;
         end else begin
            rsp_hold <= $urandom_range(0, 8);
         end
      end else begin
         rsp_tready <= 1'b1;
         rsp_hold <= $urandom_range(0, 8);
      end
   end

   always @(posedge clock) begin : rsp_monitor
      gap_event_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.kind = fvg_pkg::event_kind_type'(rsp_tuser[1:0]);
         got.is_up = rsp_tuser[2];
         got.begin_idx = rsp_tdata[31:0];
         got.start_val = rsp_tdata[63:32];
         got.end_val = rsp_tdata[95:64];
         got.end_idx = rsp_tdata[127:96];
         got.hide = rsp_tdata[128];
         got.last = rsp_tlast;
         sb.check_event(got);
      end
   end

   // enter and leave at a falling edge
   task automatic send_bar(logic [31:0] hi, logic [31:0] lo);
      int unsigned gap;
      gap = no_idle ? 0 : idle_len();
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {lo, hi};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.take_bar(hi, lo);
      @(negedge clock);
   endtask

   task automatic wait_quiet();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic write_csr(fvg_pkg::csr_index_type idx, logic [31:0] val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      sb.set_reg(idx, val);
      @(negedge clock);
      csr_wr_en <= 1'b0;
      @(negedge clock);
   endtask

   // drive random upper bits; only bit 0 counts
   task automatic write_flag(fvg_pkg::csr_index_type idx, bit b);
      write_csr(idx, ($urandom & 32'hFFFF_FFFE) | 32'(b));
   endtask

   task automatic run_market(int unsigned count);
      int unsigned sent;
      int unsigned kind, seg, step, width;
      bit          rising;
      sent = 0;
      while (sent < count) begin
         kind = $urandom_range(0, 9);
         no_idle = ($urandom_range(0, 3) == 0);
         if (market_level < 32'h0001_0000 || market_level > 32'hFFFE_0000) begin
            market_level = $urandom_range(32'h0001_0000, 32'hFFFE_0000);
         end
         if (kind < 6) begin
            seg = $urandom_range(3, 10);
            rising = $urandom_range(0, 1);
            step = $urandom_range(1, 50);
            width = $urandom_range(0, 20);
            repeat (seg) begin
               market_level = rising ? market_level + step : market_level - step;
               send_bar(market_level + width, market_level);
               sent++;
            end
         end else if (kind < 8) begin
            send_bar(market_level + $urandom_range(0, 600), market_level - $urandom_range(0, 600));
            sent++;
         end else begin
            send_bar($urandom, $urandom);
            sent++;
         end
      end
      no_idle = 0;
   endtask

   // steady trend that overflows the table, then one bar that fills it
   task automatic fill_table(int unsigned count);
      bit          rising;
      logic [31:0] base;
      rising = $urandom_range(0, 1);
      no_idle = $urandom_range(0, 1);
      base = rising ? $urandom_range(32'h100, 32'h7000_0000)
                    : $urandom_range(32'h8000_0000, 32'hFFFF_F000);
      for (int i = 0; i < count; i++) begin
         if (rising) send_bar(base + 10 * i + 3, base + 10 * i);
         else send_bar(base - 10 * i, base - 10 * i - 3);
      end
      if (rising) send_bar(base, 32'd0);
      else send_bar(32'hFFFF_FFFF, base);
      no_idle = 0;
   endtask

   initial begin
      sb = new();
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      csr_wr_en = 1'b0;
      csr_index = fvg_pkg::CSR_UP_ENABLE;
      csr_wdata = '0;
      repeat (11) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // warm-up, both directions, fills at the edge, extremes, inverted bars
      send_bar(32'd10, 32'd5);
      send_bar(32'd20, 32'd15);
      send_bar(32'd30, 32'd11);
      send_bar(32'd40, 32'd25);
      send_bar(32'd45, 32'd20);
      send_bar(32'd12, 32'd9);
      send_bar(32'd24, 32'd22);
      send_bar(32'd25, 32'd23);
      send_bar(32'hFFFF_FFFF, 32'd0);
      send_bar(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_bar(32'd0, 32'd0);
      send_bar(32'd0, 32'hFFFF_FFFF);
      send_bar(32'd5, 32'h8000_0000);
      send_bar(32'd100, 32'd200);
      send_bar(32'hFFFF_FFFF, 32'd0);
      send_bar(32'h7FFF_FFFF, 32'h7FFF_FFF0);
      send_bar(32'h5555_5555, 32'hAAAA_AAAA);
      send_bar(32'hAAAA_AAAA, 32'h5555_5555);
      wait_quiet();

      write_flag(fvg_pkg::CSR_UP_ENABLE, 1'b1);
      write_flag(fvg_pkg::CSR_DOWN_ENABLE, 1'b0);
      write_csr(fvg_pkg::CSR_UP_MIN_GAP, 32'd0);
      write_csr(fvg_pkg::CSR_DOWN_MIN_GAP, 32'd7);
      write_flag(fvg_pkg::CSR_UP_HIDE_FILLED, 1'b0);
      write_flag(fvg_pkg::CSR_DOWN_HIDE_FILLED, 1'b1);
      write_flag(fvg_pkg::CSR_UP_EXTEND, 1'b0);
      write_flag(fvg_pkg::CSR_DOWN_EXTEND, 1'b1);
      run_market(14);
      wait_quiet();

      write_flag(fvg_pkg::CSR_DOWN_ENABLE, 1'b1);
      write_csr(fvg_pkg::CSR_UP_MIN_GAP, 32'hFFFF_FFFF);
      write_csr(fvg_pkg::CSR_DOWN_MIN_GAP, 32'd0);
      write_flag(fvg_pkg::CSR_UP_HIDE_FILLED, 1'b1);
      write_flag(fvg_pkg::CSR_DOWN_HIDE_FILLED, 1'b0);
      write_flag(fvg_pkg::CSR_UP_EXTEND, 1'b1);
      write_flag(fvg_pkg::CSR_DOWN_EXTEND, 1'b0);
      send_bar(32'd0, 32'd0);
      send_bar(32'd1, 32'd0);
      send_bar(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      run_market(8);
      wait_quiet();

      write_flag(fvg_pkg::CSR_UP_ENABLE, 1'b0);
      write_csr(fvg_pkg::CSR_UP_MIN_GAP, $urandom_range(1, 16));
      write_csr(fvg_pkg::CSR_DOWN_MIN_GAP, $urandom_range(1, 16));
      write_flag(fvg_pkg::CSR_UP_HIDE_FILLED, $urandom_range(0, 1));
      write_flag(fvg_pkg::CSR_DOWN_HIDE_FILLED, $urandom_range(0, 1));
      write_flag(fvg_pkg::CSR_UP_EXTEND, $urandom_range(0, 1));
      write_flag(fvg_pkg::CSR_DOWN_EXTEND, $urandom_range(0, 1));
      run_market(8);
      wait_quiet();

      write_flag(fvg_pkg::CSR_UP_ENABLE, 1'b1);
      write_flag(fvg_pkg::CSR_DOWN_ENABLE, 1'b1);
      write_csr(fvg_pkg::CSR_UP_MIN_GAP, $urandom_range(1, 16));
      write_csr(fvg_pkg::CSR_DOWN_MIN_GAP, $urandom_range(1, 16));
      write_flag(fvg_pkg::CSR_UP_HIDE_FILLED, $urandom_range(0, 1));
      write_flag(fvg_pkg::CSR_DOWN_HIDE_FILLED, $urandom_range(0, 1));
      write_flag(fvg_pkg::CSR_UP_EXTEND, $urandom_range(0, 1));
      write_flag(fvg_pkg::CSR_DOWN_EXTEND, $urandom_range(0, 1));
      fill_table(36);
      run_market(6);
      wait_quiet();
      run_market(6);
      wait_quiet();

      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("[fair_value_gap_tracker] OK");
      end else begin
         $display("[fair_value_gap_tracker] ERROR");
      end
      $finish;
   end

endmodule
